@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside of reset
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ src/cflt_pkg.sv @@
// ----------------------------------------------------------------------------
// cflt_pkg
// shared constants, character classes and inter-module types of the tokenizer
// ----------------------------------------------------------------------------
package cflt_pkg;

  // default sizes
  localparam int LINE_CHARS_DEF  = 80;
  localparam int FIELD_LIMIT_DEF = 6;

  // fixed field widths
  localparam int CH_W      = 8;
  localparam int STORE_W   = 7;
  localparam int VAL_W     = 32;
  localparam int IDX_OUT_W = 3;
  localparam int POS_OUT_W = 7;
  localparam int TOT_OUT_W = 3;

  // widths covering the whole parameter range
  localparam int FIDX_MAX_W = 4;  // field slot, up to 16 fields
  localparam int POS_MAX_W  = 8;  // line position, up to 255 characters
  localparam int CNT_MAX_W  = 5;  // field count, 0..16

  // character codes
  localparam logic [CH_W-1:0] CH_BS    = 8'd8;
  localparam logic [CH_W-1:0] CH_CR    = 8'd13;
  localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CH_W-1:0] CH_DEL   = 8'd127;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;

  // class bounds, exclusive on both ends
  localparam logic [STORE_W-1:0] DIG_LO = 7'd47;
  localparam logic [STORE_W-1:0] DIG_HI = 7'd58;
  localparam logic [STORE_W-1:0] UPR_LO = 7'd64;
  localparam logic [STORE_W-1:0] UPR_HI = 7'd91;
  localparam logic [STORE_W-1:0] LWR_LO = 7'd96;
  localparam logic [STORE_W-1:0] LWR_HI = 7'd123;

  // field slot write from the walk into the field table
  typedef struct packed {
    logic                  we;
    logic [FIDX_MAX_W-1:0] addr;
    logic [POS_MAX_W-1:0]  start;
    logic                  num;
    logic [VAL_W-1:0]      val;
  } fld_wr_t;

  // line close handoff to the record emitter
  typedef struct packed {
    logic                 start;
    logic [CNT_MAX_W-1:0] total;
  } line_close_t;

  function automatic logic is_digit(logic [STORE_W-1:0] c);
    is_digit = (c > DIG_LO) && (c < DIG_HI);
  endfunction

  function automatic logic is_letter(logic [STORE_W-1:0] c);
    is_letter = ((c > UPR_LO) && (c < UPR_HI)) || ((c > LWR_LO) && (c < LWR_HI));
  endfunction

endpackage

@@ src/cflt_scan.sv @@
// ----------------------------------------------------------------------------
// cflt_scan
// line store, character intake and the line-end walk that finds the fields
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cflt_scan #(
  parameter int LINE_CHARS  = cflt_pkg::LINE_CHARS_DEF,
  parameter int FIELD_LIMIT = cflt_pkg::FIELD_LIMIT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [cflt_pkg::CH_W-1:0]   rx_char_i,
  input  logic                        rx_valid_i,
  output logic                        rx_stall_o,
  input  logic                        emit_busy_i,
  output cflt_pkg::fld_wr_t           fld_wr_o,
  output cflt_pkg::line_close_t       close_o
);
  import cflt_pkg::*;

  localparam int AW  = $clog2(LINE_CHARS);
  localparam int CCW = $clog2(LINE_CHARS + 1);
  localparam int FCW = $clog2(FIELD_LIMIT + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAIT = 3'b010,
    S_WALK = 3'b100
  } scan_state_e;

  scan_state_e state_q, state_d;
  logic [CCW-1:0]   count_q, count_d;
  logic [CCW-1:0]   n_q, n_d;
  logic [CCW-1:0]   rd_q, rd_d;
  logic             pipe_vld_q, pipe_vld_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [FCW-1:0]   found_q, found_d;
  logic             inside_q, inside_d;
  logic             stop_q, stop_d;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic [AW-1:0]    start_q, start_d;
  logic             num_q, num_d;

  logic [STORE_W-1:0] line_mem [LINE_CHARS];
  logic [STORE_W-1:0] rdata_q;

  logic             rx_acc, is_cr, is_bs, is_prn;
  logic             wr_en, rd_en, walk_done, proc;
  logic [CCW-1:0]   count_inc;
  logic             c_dig, c_aln;
  logic [VAL_W-1:0] digit_val, acc_next;

  // intake decode
  assign rx_acc     = rx_valid_i && (state_q == S_IDLE);
  assign rx_stall_o = (state_q != S_IDLE);
  assign is_cr      = (rx_char_i == CH_CR);
  assign is_bs      = (rx_char_i == CH_BS) || (rx_char_i == CH_DEL);
  assign is_prn     = (rx_char_i >= CH_SPACE) && (rx_char_i < CH_DEL);
  assign count_inc  = count_q + 1'b1;
  assign wr_en      = rx_acc && is_prn && (count_q < CCW'(LINE_CHARS));

  // walk control
  assign rd_en     = (state_q == S_WALK) && !stop_q && (rd_q < n_q);
  assign walk_done = (state_q == S_WALK) && (stop_q || ((rd_q == n_q) && !pipe_vld_q));
  assign proc      = pipe_vld_q && !stop_q;

  // character class and decimal step
  assign c_dig     = is_digit(rdata_q);
  assign c_aln     = c_dig || is_letter(rdata_q);
  assign digit_val = VAL_W'(rdata_q) - VAL_W'(CH_ZERO);
  assign acc_next  = {acc_q[VAL_W-4:0], 3'b000} + {acc_q[VAL_W-2:0], 1'b0} + digit_val;

  // line store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[count_q[AW-1:0]] <= rx_char_i[STORE_W-1:0];
    end
    if (rd_en) begin
      rdata_q <= line_mem[rd_q[AW-1:0]];
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    n_d        = n_q;
    rd_d       = rd_q;
    pipe_vld_d = pipe_vld_q;
    pos_d      = pos_q;
    found_d    = found_q;
    inside_d   = inside_q;
    stop_d     = stop_q;
    acc_d      = acc_q;
    start_d    = start_q;
    num_d      = num_q;
    fld_wr_o   = '0;
    close_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (rx_acc) begin
          if (is_cr) begin
            state_d = S_WAIT;
          end else if (is_bs) begin
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
            end
          end else if (wr_en) begin
            count_d = count_inc;
            if (count_inc == CCW'(LINE_CHARS)) begin
              state_d = S_WAIT;
            end
          end
        end
      end
      S_WAIT: begin
        // the field table is free once the emitter has finished
        if (!emit_busy_i) begin
          state_d    = S_WALK;
          n_d        = count_q;
          rd_d       = '0;
          pipe_vld_d = 1'b0;
          found_d    = '0;
          inside_d   = 1'b0;
          stop_d     = 1'b0;
          acc_d      = '0;
        end
      end
      S_WALK: begin
        pipe_vld_d = rd_en;
        pos_d      = rd_q[AW-1:0];
        if (rd_en) begin
          rd_d = rd_q + 1'b1;
        end
        // classify the character read last cycle
        if (proc) begin
          if (c_aln) begin
            if (!inside_q) begin
              if (found_q >= FCW'(FIELD_LIMIT)) begin
                stop_d = 1'b1;
              end else begin
                found_d        = found_q + 1'b1;
                inside_d       = 1'b1;
                start_d        = pos_q;
                num_d          = c_dig;
                acc_d          = c_dig ? digit_val : '0;
                fld_wr_o.we    = 1'b1;
                fld_wr_o.addr  = FIDX_MAX_W'(found_q);
                fld_wr_o.start = POS_MAX_W'(pos_q);
                fld_wr_o.num   = c_dig;
                fld_wr_o.val   = c_dig ? digit_val : '0;
              end
            end else begin
              acc_d          = num_q ? acc_next : '0;
              fld_wr_o.we    = 1'b1;
              fld_wr_o.addr  = FIDX_MAX_W'(found_q - 1'b1);
              fld_wr_o.start = POS_MAX_W'(start_q);
              fld_wr_o.num   = num_q;
              fld_wr_o.val   = num_q ? acc_next : '0;
            end
          end else begin
            inside_d = 1'b0;
          end
        end
        // hand the line to the emitter and empty the store
        if (walk_done) begin
          state_d       = S_IDLE;
          close_o.start = 1'b1;
          close_o.total = CNT_MAX_W'(found_q);
          count_d       = '0;
          rd_d          = '0;
          pipe_vld_d    = 1'b0;
          found_d       = '0;
          inside_d      = 1'b0;
          stop_d        = 1'b0;
          acc_d         = '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      n_q        <= '0;
      rd_q       <= '0;
      pipe_vld_q <= 1'b0;
      found_q    <= '0;
      inside_q   <= 1'b0;
      stop_q     <= 1'b0;
      acc_q      <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      n_q        <= n_d;
      rd_q       <= rd_d;
      pipe_vld_q <= pipe_vld_d;
      found_q    <= found_d;
      inside_q   <= inside_d;
      stop_q     <= stop_d;
      acc_q      <= acc_d;
    end
  end

  // current field attributes
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    start_q <= start_d;
    num_q   <= num_d;
  end

  `ASSERT_RST(a_close_emit_idle, close_o.start |-> !emit_busy_i, "line handed to busy emitter")
  `ASSERT_RST(a_idle_count_room, (state_q == S_IDLE) |-> (count_q < CCW'(LINE_CHARS)), "full line left open")
  `ASSERT_ALWAYS(a_found_limit, found_q <= FCW'(FIELD_LIMIT), "field count past limit")

endmodule

@@ src/cflt_emit.sv @@
// ----------------------------------------------------------------------------
// cflt_emit
// field table and record output register, one record per found field, one empty record if none
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cflt_emit #(
  parameter int LINE_CHARS  = cflt_pkg::LINE_CHARS_DEF,
  parameter int FIELD_LIMIT = cflt_pkg::FIELD_LIMIT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cflt_pkg::fld_wr_t                 fld_wr_i,
  input  cflt_pkg::line_close_t             close_i,
  output logic                              busy_o,
  output logic                              rec_valid_o,
  input  logic                              rec_stall_i,
  output logic                              field_valid_o,
  output logic [cflt_pkg::IDX_OUT_W-1:0]    field_index_o,
  output logic [cflt_pkg::POS_OUT_W-1:0]    start_position_o,
  output logic                              is_numeric_o,
  output logic signed [cflt_pkg::VAL_W-1:0] numeric_value_o,
  output logic [cflt_pkg::TOT_OUT_W-1:0]    total_fields_o,
  output logic                              last_record_o
);
  import cflt_pkg::*;

  localparam int AW     = $clog2(LINE_CHARS);
  localparam int FIDX_W = (FIELD_LIMIT > 1) ? $clog2(FIELD_LIMIT) : 1;
  localparam int FCW    = $clog2(FIELD_LIMIT + 1);
  localparam int ENT_W  = AW + 1 + VAL_W;

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_READ = 4'b0010,
    E_LOAD = 4'b0100,
    E_SHOW = 4'b1000
  } emit_state_e;

  emit_state_e state_q, state_d;
  logic [FIDX_W-1:0] k_q, k_d;
  logic [FCW-1:0]    total_q, total_d;

  logic [ENT_W-1:0] fld_mem [FIELD_LIMIT];
  logic [ENT_W-1:0] rdata_q;

  logic rec_acc, load_rec, load_empty, is_last;

  logic                 fv_q, num_q, last_q;
  logic [IDX_OUT_W-1:0] fidx_q;
  logic [POS_OUT_W-1:0] pos_q;
  logic [VAL_W-1:0]     val_q;
  logic [TOT_OUT_W-1:0] tot_q;

  assign rec_valid_o = (state_q == E_SHOW);
  assign busy_o      = (state_q != E_IDLE);
  assign rec_acc     = rec_valid_o && !rec_stall_i;
  assign load_rec    = (state_q == E_LOAD);
  assign load_empty  = (state_q == E_IDLE) && close_i.start && (close_i.total == '0);
  assign is_last     = ((FCW'(k_q) + 1'b1) == total_q);

  // field table, written by the walk, read one slot at a time
  always_ff @(posedge clk_i) begin
    if (fld_wr_i.we) begin
      fld_mem[fld_wr_i.addr[FIDX_W-1:0]] <= {fld_wr_i.start[AW-1:0], fld_wr_i.num, fld_wr_i.val};
    end
    rdata_q <= fld_mem[k_q];
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    total_d = total_q;
    unique case (state_q)
      E_IDLE: begin
        if (close_i.start) begin
          k_d     = '0;
          total_d = close_i.total[FCW-1:0];
          state_d = (close_i.total == '0) ? E_SHOW : E_READ;
        end
      end
      E_READ: begin
        state_d = E_LOAD;
      end
      E_LOAD: begin
        state_d = E_SHOW;
      end
      E_SHOW: begin
        if (rec_acc) begin
          if (last_q) begin
            state_d = E_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = E_READ;
          end
        end
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      k_q     <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      total_q <= total_d;
    end
  end

  // record output register
  always_ff @(posedge clk_i) begin
    if (load_rec) begin
      fv_q   <= 1'b1;
      fidx_q <= IDX_OUT_W'(k_q);
      pos_q  <= POS_OUT_W'(rdata_q[ENT_W-1 -: AW]);
      num_q  <= rdata_q[VAL_W];
      val_q  <= rdata_q[VAL_W-1:0];
      tot_q  <= TOT_OUT_W'(total_q);
      last_q <= is_last;
    end else if (load_empty) begin
      fv_q   <= 1'b0;
      fidx_q <= '0;
      pos_q  <= '0;
      num_q  <= 1'b0;
      val_q  <= '0;
      tot_q  <= '0;
      last_q <= 1'b1;
    end
  end

  assign field_valid_o    = fv_q;
  assign field_index_o    = fidx_q;
  assign start_position_o = pos_q;
  assign is_numeric_o     = num_q;
  assign numeric_value_o  = val_q;
  assign total_fields_o   = tot_q;
  assign last_record_o    = last_q;

  `ASSERT_RST(a_start_when_idle, close_i.start |-> (state_q == E_IDLE), "line close while emitting")
  `ASSERT_RST(a_slot_in_range, (state_q == E_LOAD) |-> (FCW'(k_q) < total_q), "slot past field count")
  `ASSERT_RST(a_empty_is_last, (rec_valid_o && !fv_q) |-> last_q, "empty-line record not last")

endmodule

@@ src/command_line_field_tokenizer.sv @@
// ----------------------------------------------------------------------------
// command_line_field_tokenizer
// collects a command line and reports its alphanumeric fields on close
// ----------------------------------------------------------------------------
//  channel  direction  handshake                    payload
//  rx       in         rx_valid_i / rx_stall_o      rx_char_i
//  rec      out        rec_valid_o / rec_stall_i    field_valid_o .. last_record_o
//
//  while the line is open rx_stall_o is low and each character word is taken
//  on close: handoff once the emitter is idle, then a walk over the stored
//  characters, then each record passes the read, load and show states (the
//  empty-line record goes straight to show), held in show under output stalls
//  input stalls from the line close to the end of the walk; characters of the
//  next line are taken while records of the previous line are still emitted
//  reset clears the counters and state, the line store keeps no reset value
// ----------------------------------------------------------------------------
module command_line_field_tokenizer #(
  parameter int LINE_CHARS  = cflt_pkg::LINE_CHARS_DEF,
  parameter int FIELD_LIMIT = cflt_pkg::FIELD_LIMIT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cflt_pkg::CH_W-1:0]         rx_char_i,
  input  logic                              rx_valid_i,
  output logic                              rx_stall_o,
  output logic                              rec_valid_o,
  input  logic                              rec_stall_i,
  output logic                              field_valid_o,
  output logic [cflt_pkg::IDX_OUT_W-1:0]    field_index_o,
  output logic [cflt_pkg::POS_OUT_W-1:0]    start_position_o,
  output logic                              is_numeric_o,
  output logic signed [cflt_pkg::VAL_W-1:0] numeric_value_o,
  output logic [cflt_pkg::TOT_OUT_W-1:0]    total_fields_o,
  output logic                              last_record_o
);
  import cflt_pkg::*;

  fld_wr_t     fld_wr;
  line_close_t line_close;
  logic        emit_busy;

  // line intake and field walk
  cflt_scan #(
    .LINE_CHARS  (LINE_CHARS),
    .FIELD_LIMIT (FIELD_LIMIT)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_char_i   (rx_char_i),
    .rx_valid_i  (rx_valid_i),
    .rx_stall_o  (rx_stall_o),
    .emit_busy_i (emit_busy),
    .fld_wr_o    (fld_wr),
    .close_o     (line_close)
  );

  // record emission
  cflt_emit #(
    .LINE_CHARS  (LINE_CHARS),
    .FIELD_LIMIT (FIELD_LIMIT)
  ) u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fld_wr_i         (fld_wr),
    .close_i          (line_close),
    .busy_o           (emit_busy),
    .rec_valid_o      (rec_valid_o),
    .rec_stall_i      (rec_stall_i),
    .field_valid_o    (field_valid_o),
    .field_index_o    (field_index_o),
    .start_position_o (start_position_o),
    .is_numeric_o     (is_numeric_o),
    .numeric_value_o  (numeric_value_o),
    .total_fields_o   (total_fields_o),
    .last_record_o    (last_record_o)
  );

endmodule
